>>> rtl/fbpa_pkg.sv
package fbpa_pkg;

  // Field widths of the channels and the configuration port.
  localparam int ACTION_W   = 2;
  localparam int ADDR_W     = 32;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 9;
  localparam int BSIZE_W    = 16;
  localparam int POOL_W     = 9;
  localparam int TOTAL_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Build defaults and reset values.
  localparam int DEF_MAX_BLOCKS = 256;
  localparam int DEF_ADDR_BITS  = 32;
  localparam int POOL_RESET     = 256;
  localparam int BSIZE_RESET    = 16;

  // The block index within the pool never exceeds what the pool register holds.
  localparam int QUOT_BITS = POOL_W;
  localparam int SPAN_W    = BSIZE_W + QUOT_BITS;

  // Actions.
  localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BSIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POOL  = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_ADD,
    S_DIV,
    S_DONE
  } state_t;

  // Status of the remainder unit towards the sequencer.
  typedef struct packed {
    logic done;
    logic rem_zero;
  } rem_res_t;

endpackage

>>> rtl/fbpa_if.sv
interface fbpa_in_if;
  logic                          valid;
  logic                          ready;
  logic [fbpa_pkg::ACTION_W-1:0] action;
  logic [fbpa_pkg::ADDR_W-1:0]   address;

  modport source (output valid, output action, output address, input ready);
  modport sink (input valid, input action, input address, output ready);
endinterface

interface fbpa_out_if;
  logic                          valid;
  logic                          ready;
  logic [fbpa_pkg::STATUS_W-1:0] status;
  logic [fbpa_pkg::ADDR_W-1:0]   block_address;
  logic [fbpa_pkg::COUNT_W-1:0]  in_use;
  logic [fbpa_pkg::COUNT_W-1:0]  peak_in_use;
  logic [fbpa_pkg::TOTAL_W-1:0]  total_allocated;
  logic [fbpa_pkg::TOTAL_W-1:0]  total_freed;

  modport source (output valid, output status, output block_address, output in_use,
                  output peak_in_use, output total_allocated, output total_freed,
                  input ready);
  modport sink (input valid, input status, input block_address, input in_use,
                input peak_in_use, input total_allocated, input total_freed,
                output ready);
endinterface

>>> rtl/fbpa_stack.sv
module fbpa_stack #(
  parameter int DEPTH  = fbpa_pkg::DEF_MAX_BLOCKS,
  parameter int DATA_W = fbpa_pkg::ADDR_W,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data follows in the cycle after the read enable.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/fbpa_rem.sv
module fbpa_rem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [fbpa_pkg::SPAN_W-1:0] dividend,
  input  logic [fbpa_pkg::BSIZE_W-1:0] divisor,
  output fbpa_pkg::rem_res_t          res
);

  localparam int CNT_W = $clog2(fbpa_pkg::QUOT_BITS + 1);

  logic [fbpa_pkg::SPAN_W-1:0] rem_r;
  logic [fbpa_pkg::SPAN_W-1:0] dsr_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        done_r;

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (start) begin
        cnt_r <= CNT_W'(fbpa_pkg::QUOT_BITS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  // Restoring remainder, one quotient bit per cycle from the top bit down.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dsr_r <= fbpa_pkg::SPAN_W'(divisor) << (fbpa_pkg::QUOT_BITS - 1);
    end else if (cnt_r != '0) begin
      if (rem_r >= dsr_r) begin
        rem_r <= rem_r - dsr_r;
      end
      dsr_r <= dsr_r >> 1;
    end
  end

  assign res.done     = done_r;
  assign res.rem_zero = (rem_r == '0);

endmodule

>>> rtl/fixed_block_pool_allocator_core.sv
// An allocate that hands out a block passes through a pop or add state before the result beat;
// a free that passes the range check waits on the nine-step alignment remainder unit.
// One item is worked on at a time: no new beat is taken until the last result is loaded; the
// freed-block stack memory is read or written at most once per item.
// Reset is synchronous and active low: it refills the pool and clears every counter;
// the stack memory is not cleared, since it is only read below the stack depth.
module fixed_block_pool_allocator_core #(
  parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS,
  parameter int ADDR_BITS  = fbpa_pkg::DEF_ADDR_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fbpa_in_if.sink                         in_ch,
  fbpa_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SW       = (ADDR_BITS < fbpa_pkg::ADDR_W) ? ADDR_BITS : fbpa_pkg::ADDR_W;
  localparam int DW       = $clog2(MAX_BLOCKS + 1);
  localparam int AW       = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int POOL_MAX = (1 << fbpa_pkg::POOL_W) - 1;
  localparam int MAX_CAP  = (MAX_BLOCKS > POOL_MAX) ? POOL_MAX : MAX_BLOCKS;
  localparam int RST_POOL = (MAX_BLOCKS < fbpa_pkg::POOL_RESET) ? MAX_BLOCKS
                                                                 : fbpa_pkg::POOL_RESET;
  localparam int SUM_W    = ((DW > fbpa_pkg::POOL_W) ? DW : fbpa_pkg::POOL_W) + 1;
  localparam int CMP_W    = (SW > fbpa_pkg::SPAN_W) ? SW : fbpa_pkg::SPAN_W;

  // Configuration registers.
  logic [fbpa_pkg::ADDR_W-1:0]  base_r;
  logic [fbpa_pkg::BSIZE_W-1:0] bsize_r;
  logic [fbpa_pkg::POOL_W-1:0]  pblk_r;
  logic [fbpa_pkg::POOL_W-1:0]  eff;
  logic [fbpa_pkg::SPAN_W-1:0]  span_r;

  // Pool state.
  logic [DW-1:0]                depth_r, depth_nxt;
  logic [fbpa_pkg::POOL_W-1:0]  fresh_r, fresh_nxt;
  logic [fbpa_pkg::COUNT_W-1:0] inuse_r, inuse_nxt;
  logic [fbpa_pkg::COUNT_W-1:0] peak_r, peak_nxt;
  logic [fbpa_pkg::TOTAL_W-1:0] atot_r, atot_nxt;
  logic [fbpa_pkg::TOTAL_W-1:0] ftot_r, ftot_nxt;

  // Item in progress.
  fbpa_pkg::state_t              state_r, state_nxt;
  logic [fbpa_pkg::ACTION_W-1:0] act_r, act_nxt;
  logic [SW-1:0]                 addr_r, addr_nxt;
  logic [fbpa_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [fbpa_pkg::ADDR_W-1:0]   handed_r, handed_nxt;
  logic [fbpa_pkg::SPAN_W-1:0]   prod_r, prod_nxt;

  // Output register.
  logic                          ovalid_r, ovalid_nxt;
  logic                          out_load;
  logic [fbpa_pkg::STATUS_W-1:0] o_status_r;
  logic [fbpa_pkg::ADDR_W-1:0]   o_addr_r;
  logic [fbpa_pkg::COUNT_W-1:0]  o_inuse_r;
  logic [fbpa_pkg::COUNT_W-1:0]  o_peak_r;
  logic [fbpa_pkg::TOTAL_W-1:0]  o_atot_r;
  logic [fbpa_pkg::TOTAL_W-1:0]  o_ftot_r;

  // Datapath helpers.
  logic [SW-1:0]                base_m;
  logic [SW-1:0]                off;
  logic [CMP_W-1:0]             off_ext;
  logic [CMP_W-1:0]             span_ext;
  logic [DW-1:0]                depth_dec;
  logic [fbpa_pkg::POOL_W-1:0]  fresh_dec;
  logic [fbpa_pkg::COUNT_W-1:0] inuse_inc;
  logic [fbpa_pkg::COUNT_W-1:0] peak_inc;
  logic                         stack_full;
  logic [fbpa_pkg::ADDR_W-1:0]  add_sum;

  // Memory and remainder unit connections.
  logic                 mem_we;
  logic                 mem_re;
  logic [SW-1:0]        mem_rdata;
  logic                 rem_start;
  fbpa_pkg::rem_res_t   rem_res;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      bsize_r <= fbpa_pkg::BSIZE_W'(fbpa_pkg::BSIZE_RESET);
      pblk_r  <= fbpa_pkg::POOL_W'(fbpa_pkg::POOL_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        fbpa_pkg::REG_BASE:  base_r  <= cfg_wdata;
        fbpa_pkg::REG_BSIZE: bsize_r <= cfg_wdata[fbpa_pkg::BSIZE_W-1:0];
        fbpa_pkg::REG_POOL:  pblk_r  <= cfg_wdata[fbpa_pkg::POOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective pool size and its byte span, kept ready for the range check.
  assign eff = (pblk_r > fbpa_pkg::POOL_W'(MAX_CAP)) ? fbpa_pkg::POOL_W'(MAX_CAP) : pblk_r;

  always_ff @(posedge clk) begin
    span_r <= fbpa_pkg::SPAN_W'(bsize_r) * fbpa_pkg::SPAN_W'(eff);
  end

  // Address arithmetic and count helpers.
  assign base_m     = base_r[SW-1:0];
  assign off        = addr_r - base_m;
  assign off_ext    = CMP_W'(off);
  assign span_ext   = CMP_W'(span_r);
  assign depth_dec  = depth_r - DW'(1);
  assign fresh_dec  = fresh_r - fbpa_pkg::POOL_W'(1);
  assign inuse_inc  = (inuse_r == '1) ? inuse_r : inuse_r + fbpa_pkg::COUNT_W'(1);
  assign peak_inc   = (inuse_inc > peak_r) ? inuse_inc : peak_r;
  assign stack_full = (depth_r >= DW'(MAX_BLOCKS)) ||
                      (SUM_W'(depth_r) + SUM_W'(fresh_r) >= SUM_W'(eff));
  assign add_sum    = base_r + fbpa_pkg::ADDR_W'(prod_r);

  // Sequencer: next state, state updates and memory controls.
  always_comb begin
    state_nxt  = state_r;
    act_nxt    = act_r;
    addr_nxt   = addr_r;
    status_nxt = status_r;
    handed_nxt = handed_r;
    prod_nxt   = prod_r;
    depth_nxt  = depth_r;
    fresh_nxt  = fresh_r;
    inuse_nxt  = inuse_r;
    peak_nxt   = peak_r;
    atot_nxt   = atot_r;
    ftot_nxt   = ftot_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    rem_start  = 1'b0;
    out_load   = 1'b0;
    ovalid_nxt = ovalid_r && !out_ch.ready;

    unique case (state_r)
      fbpa_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          act_nxt    = in_ch.action;
          addr_nxt   = in_ch.address[SW-1:0];
          status_nxt = fbpa_pkg::ST_OK;
          handed_nxt = '0;
          state_nxt  = fbpa_pkg::S_EXEC;
        end
      end

      fbpa_pkg::S_EXEC: begin
        case (act_r)
          fbpa_pkg::ACT_ALLOC: begin
            if (depth_r != '0) begin
              // Reuse the most recently freed block.
              mem_re    = 1'b1;
              depth_nxt = depth_dec;
              atot_nxt  = atot_r + fbpa_pkg::TOTAL_W'(1);
              inuse_nxt = inuse_inc;
              peak_nxt  = peak_inc;
              state_nxt = fbpa_pkg::S_POP;
            end else if (fresh_r != '0) begin
              // Hand out the highest never-used block.
              fresh_nxt = fresh_dec;
              prod_nxt  = fbpa_pkg::SPAN_W'(fresh_dec) * fbpa_pkg::SPAN_W'(bsize_r);
              atot_nxt  = atot_r + fbpa_pkg::TOTAL_W'(1);
              inuse_nxt = inuse_inc;
              peak_nxt  = peak_inc;
              state_nxt = fbpa_pkg::S_ADD;
            end else begin
              status_nxt = fbpa_pkg::ST_EMPTY;
              state_nxt  = fbpa_pkg::S_DONE;
            end
          end
          fbpa_pkg::ACT_FREE: begin
            if (addr_r == '0) begin
              status_nxt = fbpa_pkg::ST_NULL;
              state_nxt  = fbpa_pkg::S_DONE;
            end else if (bsize_r == '0 || addr_r < base_m || off_ext >= span_ext) begin
              status_nxt = fbpa_pkg::ST_INVALID;
              state_nxt  = fbpa_pkg::S_DONE;
            end else begin
              rem_start = 1'b1;
              state_nxt = fbpa_pkg::S_DIV;
            end
          end
          fbpa_pkg::ACT_RESTART: begin
            depth_nxt = '0;
            fresh_nxt = eff;
            inuse_nxt = '0;
            peak_nxt  = '0;
            atot_nxt  = '0;
            ftot_nxt  = '0;
            state_nxt = fbpa_pkg::S_DONE;
          end
          default: begin
            state_nxt = fbpa_pkg::S_DONE;
          end
        endcase
      end

      fbpa_pkg::S_POP: begin
        handed_nxt = fbpa_pkg::ADDR_W'(mem_rdata);
        state_nxt  = fbpa_pkg::S_DONE;
      end

      fbpa_pkg::S_ADD: begin
        handed_nxt = fbpa_pkg::ADDR_W'(add_sum[SW-1:0]);
        state_nxt  = fbpa_pkg::S_DONE;
      end

      fbpa_pkg::S_DIV: begin
        if (rem_res.done) begin
          if (!rem_res.rem_zero) begin
            status_nxt = fbpa_pkg::ST_INVALID;
          end else if (stack_full) begin
            status_nxt = fbpa_pkg::ST_FULL;
          end else begin
            // Push the block onto the freed stack.
            mem_we    = 1'b1;
            depth_nxt = depth_r + DW'(1);
            if (inuse_r != '0) begin
              inuse_nxt = inuse_r - fbpa_pkg::COUNT_W'(1);
            end
            ftot_nxt = ftot_r + fbpa_pkg::TOTAL_W'(1);
          end
          state_nxt = fbpa_pkg::S_DONE;
        end
      end

      fbpa_pkg::S_DONE: begin
        if (!ovalid_r || out_ch.ready) begin
          out_load   = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = fbpa_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = fbpa_pkg::S_IDLE;
      end
    endcase
  end

  // Control and pool state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= fbpa_pkg::S_IDLE;
      ovalid_r <= 1'b0;
      depth_r  <= '0;
      fresh_r  <= fbpa_pkg::POOL_W'(RST_POOL);
      inuse_r  <= '0;
      peak_r   <= '0;
      atot_r   <= '0;
      ftot_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      depth_r  <= depth_nxt;
      fresh_r  <= fresh_nxt;
      inuse_r  <= inuse_nxt;
      peak_r   <= peak_nxt;
      atot_r   <= atot_nxt;
      ftot_r   <= ftot_nxt;
    end
  end

  // Item payload registers.
  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    addr_r   <= addr_nxt;
    status_r <= status_nxt;
    handed_r <= handed_nxt;
    prod_r   <= prod_nxt;
  end

  // Result beat register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_status_r <= status_r;
      o_addr_r   <= handed_r;
      o_inuse_r  <= inuse_r;
      o_peak_r   <= peak_r;
      o_atot_r   <= atot_r;
      o_ftot_r   <= ftot_r;
    end
  end

  // Freed-block stack memory.
  fbpa_stack #(
    .DEPTH  (MAX_BLOCKS),
    .DATA_W (SW)
  ) u_stack (
    .clk   (clk),
    .we    (mem_we),
    .waddr (depth_r[AW-1:0]),
    .wdata (addr_r),
    .re    (mem_re),
    .raddr (depth_dec[AW-1:0]),
    .rdata (mem_rdata)
  );

  // Block alignment check.
  fbpa_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (off_ext[fbpa_pkg::SPAN_W-1:0]),
    .divisor  (bsize_r),
    .res      (rem_res)
  );

  // Channel ports.
  assign in_ch.ready            = (state_r == fbpa_pkg::S_IDLE);
  assign out_ch.valid           = ovalid_r;
  assign out_ch.status          = o_status_r;
  assign out_ch.block_address   = o_addr_r;
  assign out_ch.in_use          = o_inuse_r;
  assign out_ch.peak_in_use     = o_peak_r;
  assign out_ch.total_allocated = o_atot_r;
  assign out_ch.total_freed     = o_ftot_r;

endmodule

>>> rtl/fbpa_checker.sv
module fbpa_checker (
  input logic        clk,
  input logic        rst_n,
  fbpa_in_if.sink    in_ch,
  fbpa_out_if.source out_ch
);

  // Only one item is in flight: an accepted beat closes the input until it is done.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted again while an item was in flight");

  // A stalled result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=>
      out_ch.valid && $stable(out_ch.status) && $stable(out_ch.block_address) &&
      $stable(out_ch.in_use))
    else $error("result beat changed while stalled");

  // Only a successful action carries an address.
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != fbpa_pkg::ST_OK |-> out_ch.block_address == '0)
    else $error("failed action returned a non-zero address");

  // The peak never falls below the current count.
  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.in_use <= out_ch.peak_in_use)
    else $error("in_use exceeds peak_in_use");

  // No result beat is offered straight after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result beat valid after reset");

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
